/* rtl/klx_pkg.sv */
// Shared types, constants and keyword table for the keyword lexer stream core.
`default_nettype none
package klx_pkg;

    localparam int MAX_KEYWORD_LEN = 8;
    localparam int LINE_BITS       = 16;
    localparam int LINE_W          = 16;
    localparam int WLEN_W          = $clog2(MAX_KEYWORD_LEN + 2);
    localparam int NUM_KW          = 12;
    localparam int KW_MAX_LEN      = 8;
    localparam int QDEPTH          = 4;
    localparam int QPTR_W          = $clog2(QDEPTH);
    localparam int QCNT_W          = $clog2(QDEPTH + 1);

    localparam logic [1:0] OP_CHAR = 2'd0;
    localparam logic [1:0] OP_EOL  = 2'd1;
    localparam logic [1:0] OP_EOI  = 2'd2;

    localparam logic [2:0] KIND_TEXT    = 3'd0;
    localparam logic [2:0] KIND_STR_END = 3'd1;
    localparam logic [2:0] KIND_ID_END  = 3'd2;
    localparam logic [2:0] KIND_KW_END  = 3'd3;
    localparam logic [2:0] KIND_SYMBOL  = 3'd4;
    localparam logic [2:0] KIND_NEWLINE = 3'd5;
    localparam logic [2:0] KIND_END     = 3'd6;
    localparam logic [2:0] KIND_ERROR   = 3'd7;

    // Keyword text, right justified: first character in the highest used byte
    localparam logic [8*KW_MAX_LEN-1:0] KW_STR [NUM_KW] = '{
        "function", "start", "end", "if", "elif", "else",
        "say", "set", "add", "minus", "multiply", "divide"
    };
    localparam int KW_LEN [NUM_KW] = '{8, 5, 3, 2, 4, 4, 3, 3, 3, 5, 8, 6};

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] ch;
    } in_item_t;

    typedef struct packed {
        logic [2:0]        kind;
        logic [7:0]        text_char;
        logic [3:0]        keyword_index;
        logic [LINE_W-1:0] line_number;
        logic              last;
    } out_item_t;

    // Results caused by one input item, in order
    typedef struct packed {
        logic [1:0] cnt;
        out_item_t  r0;
        out_item_t  r1;
    } pair_t;

    typedef struct packed {
        logic  wr;
        pair_t ent;
    } q_wr_t;

    typedef struct packed {
        logic  avail;
        pair_t ent;
    } q_head_t;

    // Clamp a line count to the width of the result field
    function automatic logic [LINE_W-1:0] line_cap(input logic [LINE_BITS-1:0] v);
        logic [LINE_W-1:0] r;
        if (LINE_BITS > LINE_W && (v >> LINE_W) != '0)
            r = '1;
        else
            r = LINE_W'(v);
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/klx_front.sv */
// Front end: lexer state, character classification and keyword match.
`default_nettype none
module klx_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire klx_pkg::in_item_t item,
    input  wire logic             q_full,
    output logic                  full,
    output klx_pkg::q_wr_t        q_wr
);
    import klx_pkg::*;

    typedef enum logic [2:0] {
        MODE_LINE_START,
        MODE_NORMAL,
        MODE_WORD,
        MODE_STRING,
        MODE_COMMENT,
        MODE_HALTED
    } mode_t;

    mode_t                mode_reg, mode_next;
    logic                 content_reg, content_next;
    logic [WLEN_W-1:0]    len_reg, len_next;
    logic [LINE_BITS-1:0] line_reg, line_next;
    logic [7:0]           buf_reg [MAX_KEYWORD_LEN];

    logic              accept;
    logic              buf_we;
    logic [WLEN_W-1:0] buf_idx;
    logic              do_end_word, do_normal, do_newline, do_single;
    logic [2:0]        single_kind;
    logic [7:0]        single_char;
    logic [LINE_W-1:0] single_line;
    logic [LINE_W-1:0] tok_line;
    logic [7:0]        c;
    logic              c_space, c_alpha, c_wstart, c_wchar, c_sym;
    logic              kw_hit;
    logic [3:0]        kw_idx;
    pair_t             ent;

    function automatic pair_t add_res(input pair_t p, input logic [2:0] k,
                                      input logic [7:0] ch, input logic [3:0] kwi,
                                      input logic [LINE_W-1:0] ln);
        out_item_t r;
        r = '{kind: k, text_char: ch, keyword_index: kwi, line_number: ln, last: 1'b0};
        if (p.cnt == 2'd0)
        begin
            p.r0  = r;
            p.cnt = 2'd1;
        end
        else
        begin
            p.r1  = r;
            p.cnt = 2'd2;
        end
        return p;
    endfunction

    assign full   = q_full;
    assign accept = push && !q_full;
    assign c      = item.ch;

    assign c_space  = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    assign c_alpha  = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    assign c_wstart = c_alpha || (c == "_");
    assign c_wchar  = c_wstart || (c >= "0" && c <= "9");
    assign c_sym    = (c == ":") || (c == "=") || (c == "(") || (c == ")");

    assign tok_line = line_cap((line_reg != '1) ? line_reg + 1'b1 : line_reg);

    // Compare the word buffer against every keyword at once
    always_comb
    begin
        logic same;
        kw_hit = 1'b0;
        kw_idx = '0;
        for (int k = NUM_KW - 1; k >= 0; k--)
        begin
            same = (len_reg == WLEN_W'(KW_LEN[k]));
            for (int i = 0; i < KW_MAX_LEN; i++)
            begin
                if (i < KW_LEN[k] &&
                    buf_reg[i] != KW_STR[k][(KW_LEN[k] - 1 - i) * 8 +: 8])
                    same = 1'b0;
            end
            if (same)
            begin
                kw_hit = 1'b1;
                kw_idx = 4'(k);
            end
        end
    end

    always_comb
    begin
        mode_next    = mode_reg;
        content_next = content_reg;
        len_next     = len_reg;
        line_next    = line_reg;
        buf_we       = 1'b0;
        buf_idx      = len_reg;
        do_end_word  = 1'b0;
        do_normal    = 1'b0;
        do_newline   = 1'b0;
        do_single    = 1'b0;
        single_kind  = KIND_TEXT;
        single_char  = 8'd0;
        single_line  = tok_line;
        ent          = '0;

        if (accept && mode_reg != MODE_HALTED)
        begin
            unique case (item.op)
                OP_CHAR:
                begin
                    unique case (mode_reg)
                        MODE_LINE_START:
                        begin
                            if (c == "#")
                                mode_next = MODE_COMMENT;
                            else if (!c_space)
                            begin
                                content_next = 1'b1;
                                mode_next    = MODE_NORMAL;
                                do_normal    = 1'b1;
                            end
                        end
                        MODE_NORMAL:
                            do_normal = 1'b1;
                        MODE_WORD:
                        begin
                            if (c_wchar)
                            begin
                                buf_we = (len_reg < WLEN_W'(MAX_KEYWORD_LEN));
                                if (len_reg <= WLEN_W'(MAX_KEYWORD_LEN))
                                    len_next = len_reg + 1'b1;
                                do_single   = 1'b1;
                                single_char = c;
                            end
                            else
                            begin
                                do_end_word = 1'b1;
                                mode_next   = MODE_NORMAL;
                                do_normal   = 1'b1;
                            end
                        end
                        MODE_STRING:
                        begin
                            do_single = 1'b1;
                            if (c == "\"")
                            begin
                                single_kind = KIND_STR_END;
                                mode_next   = MODE_NORMAL;
                            end
                            else
                                single_char = c;
                        end
                        default:
                            ;
                    endcase
                end
                OP_EOL:
                begin
                    if (mode_reg == MODE_STRING)
                    begin
                        do_single   = 1'b1;
                        single_kind = KIND_ERROR;
                        mode_next   = MODE_HALTED;
                    end
                    else
                    begin
                        do_end_word  = (mode_reg == MODE_WORD);
                        do_newline   = content_reg;
                        if (line_reg != '1)
                            line_next = line_reg + 1'b1;
                        mode_next    = MODE_LINE_START;
                        content_next = 1'b0;
                        len_next     = '0;
                    end
                end
                OP_EOI:
                begin
                    do_single   = 1'b1;
                    single_kind = KIND_END;
                    single_line = line_cap(line_reg);
                    mode_next   = MODE_HALTED;
                end
                default:
                    ;
            endcase
        end

        // Emit in source order: word end, then what the breaking character gives
        if (do_end_word)
        begin
            if (kw_hit)
                ent = add_res(ent, KIND_KW_END, 8'd0, kw_idx, tok_line);
            else
                ent = add_res(ent, KIND_ID_END, 8'd0, 4'd0, tok_line);
        end
        if (do_normal && !c_space)
        begin
            if (c == "\"")
                mode_next = MODE_STRING;
            else if (c_wstart)
            begin
                mode_next = MODE_WORD;
                len_next  = WLEN_W'(1);
                buf_we    = 1'b1;
                buf_idx   = '0;
                ent       = add_res(ent, KIND_TEXT, c, 4'd0, tok_line);
            end
            else if (c_sym)
                ent = add_res(ent, KIND_SYMBOL, c, 4'd0, tok_line);
        end
        if (do_newline)
            ent = add_res(ent, KIND_NEWLINE, 8'd0, 4'd0, tok_line);
        if (do_single)
            ent = add_res(ent, single_kind, single_char, 4'd0, single_line);

        if (ent.cnt == 2'd2)
            ent.r1.last = 1'b1;
        else if (ent.cnt == 2'd1)
            ent.r0.last = 1'b1;
    end

    assign q_wr.wr  = (ent.cnt != 2'd0);
    assign q_wr.ent = ent;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_LINE_START;
            content_reg <= 1'b0;
            len_reg     <= '0;
            line_reg    <= '0;
        end
        else
        begin
            mode_reg    <= mode_next;
            content_reg <= content_next;
            len_reg     <= len_next;
            line_reg    <= line_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < MAX_KEYWORD_LEN; j++)
        begin
            if (buf_we && buf_idx == WLEN_W'(j))
                buf_reg[j] <= c;
        end
    end

endmodule
`default_nettype wire

/* rtl/klx_queue.sv */
// Short queue of per-item result groups between front and back.
`default_nettype none
module klx_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire klx_pkg::q_wr_t  q_wr,
    input  wire logic            rd,
    output logic                 q_full,
    output klx_pkg::q_head_t     head
);
    import klx_pkg::*;

    pair_t             mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_wr, do_rd;

    assign q_full     = (cnt_reg == QCNT_W'(QDEPTH));
    assign head.avail = (cnt_reg != '0);
    assign head.ent   = mem[rd_ptr_reg];

    assign do_wr = q_wr.wr && !q_full;
    assign do_rd = rd && head.avail;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + 1'b1;
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= q_wr.ent;
    end

endmodule
`default_nettype wire

/* rtl/klx_back.sv */
// Back end: output register that hands out one result per pop.
`default_nettype none
module klx_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire klx_pkg::q_head_t head,
    output logic                  rd,
    output logic                  empty,
    input  wire logic             pop,
    output klx_pkg::out_item_t    result
);
    import klx_pkg::*;

    logic  valid_reg, valid_next;
    logic  sec_reg, sec_next;
    pair_t ent_reg;
    logic  take, done;

    assign empty  = !valid_reg;
    assign result = sec_reg ? ent_reg.r1 : ent_reg.r0;
    assign take   = pop && valid_reg;
    assign done   = take && (sec_reg || ent_reg.cnt != 2'd2);
    assign rd     = (!valid_reg || done) && head.avail;

    always_comb
    begin
        valid_next = valid_reg;
        sec_next   = sec_reg;
        if (rd)
        begin
            valid_next = 1'b1;
            sec_next   = 1'b0;
        end
        else if (done)
            valid_next = 1'b0;
        else if (take)
            sec_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sec_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            sec_reg   <= sec_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd)
            ent_reg <= head.ent;
    end

endmodule
`default_nettype wire

/* rtl/keyword_lexer_stream_core.sv */
// Top level of the keyword lexer stream core.
`default_nettype none
// Streaming lexer: push one item per cycle (a character, an end of line or an
// end of input) and pop token results. Each item causes zero, one or two results;
// the final one of an item carries last. An item is taken in the cycle it is
// pushed whenever the four-entry result queue has room, so the input side runs at
// one item per clock; the result side hands out one result per pop, and an item
// that causes two results needs two pops. A result is written into the queue and
// then loaded into the output register before it is visible. The lexer state and the
// parallel compare against the twelve keywords resolve within the accepting
// cycle. After an unterminated string or the end of input the block answers
// nothing until reset.
module keyword_lexer_stream_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire klx_pkg::in_item_t item,
    output logic                   empty,
    input  wire logic              pop,
    output klx_pkg::out_item_t     result
);
    import klx_pkg::*;

    q_wr_t   q_wr;
    q_head_t head;
    logic    q_full;
    logic    rd;

    klx_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .item   (item),
        .q_full (q_full),
        .full   (full),
        .q_wr   (q_wr)
    );

    klx_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_wr   (q_wr),
        .rd     (rd),
        .q_full (q_full),
        .head   (head)
    );

    klx_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .rd     (rd),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

`ifndef SYNTHESIS
    a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_wr.wr && q_full))
        else $error("result group written into a full queue");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result.kind == KIND_END || result.kind == KIND_ERROR)) |-> result.last)
        else $error("end or error result not marked last");

    a_group_has_results: assert property (@(posedge clk) disable iff (!rst_n)
        head.avail |-> (head.ent.cnt == 2'd1 || head.ent.cnt == 2'd2))
        else $error("queued result group holds no results");
`endif

endmodule
`default_nettype wire
